>>> design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Holds the channel beat structs, slot layout and control codes; no dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    // Queue geometry
    localparam int DEPTH      = 64;
    localparam int ID_BITS    = 16;
    localparam int PRI_BITS   = 32;
    localparam int PFX_LEVELS = $clog2(DEPTH);

    // Operation codes carried in the input beat
    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_CHANGE  = 2'd2,
        ACT_EXTRACT = 2'd3
    } action_t;

    // What the cells compare against the broadcast key
    typedef enum logic [1:0] {
        K_INSERT,
        K_REMOVE,
        K_EXTRACT
    } cmp_kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL,
        ST_CMP,
        ST_INS,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [ID_BITS-1:0]  entry_id;
        logic [PRI_BITS-1:0] entry_priority;
    } in_beat_t;

    typedef struct packed {
        logic                ok;
        logic [ID_BITS-1:0]  min_id;
        logic [PRI_BITS-1:0] min_priority;
        logic                is_empty;
        logic                overflow;
    } out_beat_t;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [PRI_BITS-1:0] pri;
    } slot_t;

    // Sequencer to cell row
    typedef struct packed {
        logic                cmp_en;
        cmp_kind_t           cmp_kind;
        logic [ID_BITS-1:0]  key_id;
        logic [PRI_BITS-1:0] key_pri;
        logic                shift_en;
        logic                shift_ins;
    } cmd_t;

    // Cell row to sequencer
    typedef struct packed {
        logic                head_valid;
        logic                next_valid;
        logic                head_flag;
        slot_t               head_slot;
        logic                found;
        logic                full;
    } stat_t;

endpackage

>>> design/spq_cell.sv
// One slot of the sorted row: entry, valid bit and compare flag.
// Depends on spq_pkg for the slot and command types.
`timescale 1ns / 1ps

module spq_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::cmd_t cmd,
    input  logic          head,
    input  logic          left_valid,
    input  spq_pkg::slot_t left_slot,
    input  logic          right_valid,
    input  spq_pkg::slot_t right_slot,
    input  logic          pre_prev,
    input  logic          pre_own,
    output logic          valid,
    output spq_pkg::slot_t slot,
    output logic          flag
);
    import spq_pkg::*;

    logic  valid_reg, valid_next;
    slot_t slot_reg, slot_next;
    logic  flag_reg, flag_next;

    // Compare phase: flag this cell against the broadcast key
    always_comb
    begin
        case (cmd.cmp_kind)
            K_INSERT:  flag_next = !valid_reg ||
                                   (head ? (cmd.key_pri < slot_reg.pri)
                                         : (slot_reg.pri >= cmd.key_pri));
            K_REMOVE:  flag_next = valid_reg && (slot_reg.id == cmd.key_id);
            K_EXTRACT: flag_next = head && valid_reg;
            default:   flag_next = 1'b0;
        endcase
    end

    // Shift phase: open a gap (insert) or close one (delete)
    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (cmd.shift_en)
        begin
            if (cmd.shift_ins)
            begin
                if (pre_prev)
                begin
                    valid_next = left_valid;
                    slot_next  = left_slot;
                end
                else if (flag_reg)
                begin
                    valid_next = 1'b1;
                    slot_next  = '{id: cmd.key_id, pri: cmd.key_pri};
                end
            end
            else if (pre_own)
            begin
                valid_next = right_valid;
                slot_next  = right_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        if (cmd.cmp_en)
            flag_reg <= flag_next;
    end

    assign valid = valid_reg;
    assign slot  = slot_reg;
    assign flag  = flag_reg;

endmodule

>>> design/spq_prefix.sv
// Inclusive prefix OR over the cell flags, log-depth.
// Depends on spq_pkg for DEPTH and PFX_LEVELS.
`timescale 1ns / 1ps

module spq_prefix (
    input  logic [spq_pkg::DEPTH-1:0] flags,
    output logic [spq_pkg::DEPTH-1:0] pre
);
    import spq_pkg::*;

    logic [PFX_LEVELS:0][DEPTH-1:0] lvl;

    // Each level folds in the flags 2**l positions nearer the head
    always_comb
    begin
        lvl[0] = flags;
        for (int l = 0; l < PFX_LEVELS; l++)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                if (k >= (1 << l))
                    lvl[l+1][k] = lvl[l][k] | lvl[l][k - (1 << l)];
                else
                    lvl[l+1][k] = lvl[l][k];
            end
        end
    end

    assign pre = lvl[PFX_LEVELS];

endmodule

>>> design/spq_chain.sv
// Row of DEPTH cells with the prefix network that picks the shift boundary.
// Depends on spq_pkg, spq_cell and spq_prefix.
`timescale 1ns / 1ps

module spq_chain (
    input  logic           clk,
    input  logic           rst_n,
    input  spq_pkg::cmd_t  cmd,
    output spq_pkg::stat_t stat
);
    import spq_pkg::*;

    logic [DEPTH-1:0] valid_vec;
    logic [DEPTH-1:0] flag_vec;
    logic [DEPTH-1:0] pre_vec;
    slot_t            slots [DEPTH];

    spq_prefix u_prefix (
        .flags (flag_vec),
        .pre   (pre_vec)
    );

    // Neighbors: head has nothing on the left, tail takes an empty slot on the right
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic  lv, rv, pp;
        slot_t ls, rs;

        if (k == 0)
        begin : g_head
            assign lv = 1'b0;
            assign ls = '0;
            assign pp = 1'b0;
        end
        else
        begin : g_body
            assign lv = valid_vec[k-1];
            assign ls = slots[k-1];
            assign pp = pre_vec[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_tail
            assign rv = 1'b0;
            assign rs = '0;
        end
        else
        begin : g_inner
            assign rv = valid_vec[k+1];
            assign rs = slots[k+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .head        ((k == 0) ? 1'b1 : 1'b0),
            .left_valid  (lv),
            .left_slot   (ls),
            .right_valid (rv),
            .right_slot  (rs),
            .pre_prev    (pp),
            .pre_own     (pre_vec[k]),
            .valid       (valid_vec[k]),
            .slot        (slots[k]),
            .flag        (flag_vec[k])
        );
    end

    // Status back to the sequencer
    assign stat.head_valid = valid_vec[0];
    assign stat.next_valid = valid_vec[1];
    assign stat.head_flag  = flag_vec[0];
    assign stat.head_slot  = slots[0];
    assign stat.found      = pre_vec[DEPTH-1];
    assign stat.full       = valid_vec[DEPTH-1];

    // Occupied slots always form a run starting at the head
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("valid slots not contiguous from head");

    // Occupied slots stay in nondecreasing priority order
    for (genvar k = 1; k < DEPTH; k++)
    begin : g_order_chk
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            valid_vec[k] |-> (slots[k-1].pri <= slots[k].pri))
            else $error("priority order broken in slot row");
    end

endmodule

>>> design/spq_ctrl.sv
// Operation sequencer: compare and shift phases, result assembly.
// Depends on spq_pkg for beat, command, status and state types.
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  spq_pkg::in_beat_t  in_data,
    input  logic               out_free,
    output logic               res_load,
    output spq_pkg::out_beat_t res_data,
    output spq_pkg::cmd_t      cmd,
    input  spq_pkg::stat_t     stat
);
    import spq_pkg::*;

    state_t              state_reg, state_next;
    action_t             act_reg, act_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [PRI_BITS-1:0] pri_reg, pri_next;
    logic                found_reg, found_next;
    out_beat_t           hold_reg, hold_next;

    logic      accept;
    logic      finish;
    out_beat_t res;
    logic      empty_after_del;
    logic      placed;

    assign accept          = in_valid && (state_reg == ST_IDLE);
    assign empty_after_del = !stat.head_valid || (stat.head_flag && !stat.next_valid);
    assign placed          = !stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        id_reg    <= id_next;
        pri_reg   <= pri_next;
        found_reg <= found_next;
        hold_reg  <= hold_next;
    end

    // Next state, cell commands and result
    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        id_next       = id_reg;
        pri_next      = pri_reg;
        found_next    = found_reg;
        hold_next     = hold_reg;
        in_stall      = (state_reg != ST_IDLE);
        finish        = 1'b0;
        res           = '0;
        res_load      = 1'b0;
        res_data      = hold_reg;
        cmd.cmp_en    = 1'b0;
        cmd.cmp_kind  = K_INSERT;
        cmd.key_id    = id_reg;
        cmd.key_pri   = pri_reg;
        cmd.shift_en  = 1'b0;
        cmd.shift_ins = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.key_id  = in_data.entry_id;
                cmd.key_pri = in_data.entry_priority;
                case (action_t'(in_data.action))
                    ACT_INSERT:  cmd.cmp_kind = K_INSERT;
                    ACT_EXTRACT: cmd.cmp_kind = K_EXTRACT;
                    default:     cmd.cmp_kind = K_REMOVE;
                endcase
                if (accept)
                begin
                    cmd.cmp_en = 1'b1;
                    act_next   = action_t'(in_data.action);
                    id_next    = in_data.entry_id;
                    pri_next   = in_data.entry_priority;
                    state_next = (action_t'(in_data.action) == ACT_INSERT) ? ST_INS : ST_DEL;
                end
            end

            // Drop the flagged slot and close the gap (remove, extract, first half of change)
            ST_DEL:
            begin
                cmd.shift_en = 1'b1;
                found_next   = stat.found;
                if (act_reg == ACT_CHANGE)
                    state_next = ST_CMP;
                else
                begin
                    finish       = 1'b1;
                    res.is_empty = empty_after_del;
                    if (act_reg == ACT_EXTRACT)
                    begin
                        res.ok = stat.head_valid;
                        if (stat.head_valid)
                        begin
                            res.min_id       = stat.head_slot.id;
                            res.min_priority = stat.head_slot.pri;
                        end
                    end
                    else
                        res.ok = stat.found;
                end
            end

            ST_CMP:
            begin
                cmd.cmp_en   = 1'b1;
                cmd.cmp_kind = K_INSERT;
                state_next   = ST_INS;
            end

            // Open a gap at the insert point, unless the row is full
            ST_INS:
            begin
                cmd.shift_en  = placed;
                cmd.shift_ins = 1'b1;
                finish        = 1'b1;
                res.ok        = placed && ((act_reg == ACT_INSERT) || found_reg);
                res.overflow  = !placed;
                res.is_empty  = placed ? 1'b0 : !stat.head_valid;
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase

        // Hand the result to the output register, or park it
        if (finish)
        begin
            if (out_free)
            begin
                res_load   = 1'b1;
                res_data   = res;
                state_next = ST_IDLE;
            end
            else
            begin
                hold_next  = res;
                state_next = ST_HOLD;
            end
        end
    end

    // An accepted beat is always followed by a busy state, so beats are never taken back to back
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted on consecutive cycles");

    // The insert phase always ends the operation
    a_ins_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS) |=> (state_reg == ST_IDLE || state_reg == ST_HOLD))
        else $error("insert phase did not finish the operation");

    // A change of priority runs its insert compare right after its delete
    a_change_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> ($past(state_reg) == ST_DEL && act_reg == ACT_CHANGE))
        else $error("insert compare without preceding delete");

endmodule

>>> design/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: sequencer, cell row, output register.
// Depends on spq_pkg, spq_ctrl and spq_chain.
//
//   channel | direction | handshake        | beat
//   --------+-----------+------------------+-----------------------------------------
//   in      | to core   | in_valid/stall   | action, entry_id, entry_priority
//   out     | from core | out_valid/stall  | ok, min_id, min_priority, is_empty, overflow
//
// Insert, remove and extract latch the compare flags in every cell as the beat
// is taken, then shift the row around the boundary found by the prefix OR.
// Change of priority runs a delete pass, then an insert pass.
// Reset clears all valid bits; the queue is empty and ready at once.
// A stalled output holds the finished beat; the next beat is not taken until
// the previous result has reached the output register.
`timescale 1ns / 1ps

module sorted_priority_queue_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  spq_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output spq_pkg::out_beat_t out_data
);
    import spq_pkg::*;

    cmd_t      cmd;
    stat_t     stat;
    logic      res_load;
    out_beat_t res_data;
    logic      out_free;

    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg, out_data_next;

    assign out_free = !out_valid_reg || !out_stall;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_free (out_free),
        .res_load (res_load),
        .res_data (res_data),
        .cmd      (cmd),
        .stat     (stat)
    );

    spq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> tb/testbench.sv
// Self-checking bench for sorted_priority_queue_core: a random stream of queue operations
// checked beat by beat against a sorted-list model. Depends on spq_pkg and the core.
`timescale 1ns / 1ps

module testbench;

    import spq_pkg::*;

    // Stimulus mixes for the random part
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    typedef struct {
        in_beat_t beat;
        bit       wait_drain;   // hold this beat until all results are back
    } stream_item_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_data;

    sorted_priority_queue_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Model of the queue contents
    logic [ID_BITS-1:0]  q_id  [DEPTH];
    logic [PRI_BITS-1:0] q_pri [DEPTH];
    int                  q_cnt;

    stream_item_t        op_stream[$];
    out_beat_t           op_results_q[$];
    out_beat_t           want;

    logic [ID_BITS-1:0]  id_pool  [24];
    logic [PRI_BITS-1:0] pri_pool [8];

    int  errors;
    int  outstanding;
    int  got_count;
    bit  quiet;
    bit  src_empty;
    int  gap_left;
    int  hold_left;
    bit  long_done;
    int  tx_idle_pct;
    int  rx_idle_pct;

    // Delete the entry nearest the head with this id
    function automatic bit drop_first(input logic [ID_BITS-1:0] id);
        for (int i = 0; i < q_cnt; i++) begin
            if (q_id[i] == id) begin
                for (int k = i; k + 1 < q_cnt; k++) begin
                    q_id[k]  = q_id[k + 1];
                    q_pri[k] = q_pri[k + 1];
                end
                q_cnt--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Sorted insert; a tie with the head lands behind it
    function automatic bit place_sorted(input logic [ID_BITS-1:0] id,
                                        input logic [PRI_BITS-1:0] pri);
        int pos;
        if (q_cnt >= DEPTH)
            return 1'b0;
        if (q_cnt == 0 || pri < q_pri[0]) begin
            pos = 0;
        end
        else begin
            pos = 1;
            while (pos < q_cnt && q_pri[pos] < pri)
                pos++;
        end
        for (int k = q_cnt; k > pos; k--) begin
            q_id[k]  = q_id[k - 1];
            q_pri[k] = q_pri[k - 1];
        end
        q_id[pos]  = id;
        q_pri[pos] = pri;
        q_cnt++;
        return 1'b1;
    endfunction

    // One operation on the model; returns the beat the core should send
    function automatic out_beat_t apply_queue_op(input in_beat_t b);
        out_beat_t r;
        bit        found;
        bit        placed;
        r = '0;
        case (action_t'(b.action))
            ACT_INSERT: begin
                if (place_sorted(b.entry_id, b.entry_priority))
                    r.ok = 1'b1;
                else
                    r.overflow = 1'b1;
            end
            ACT_REMOVE: begin
                r.ok = drop_first(b.entry_id);
            end
            ACT_CHANGE: begin
                found      = drop_first(b.entry_id);
                placed     = place_sorted(b.entry_id, b.entry_priority);
                r.overflow = !placed;
                r.ok       = found && placed;
            end
            default: begin
                if (q_cnt > 0) begin
                    r.min_id       = q_id[0];
                    r.min_priority = q_pri[0];
                    void'(drop_first(q_id[0]));
                    r.ok           = 1'b1;
                end
            end
        endcase
        r.is_empty = (q_cnt == 0);
        return r;
    endfunction

    function automatic in_beat_t mk_beat(input action_t a, input logic [ID_BITS-1:0] id,
                                         input logic [PRI_BITS-1:0] pri);
        in_beat_t b;
        b.action         = a;
        b.entry_id       = id;
        b.entry_priority = pri;
        return b;
    endfunction

    // Random op: ids mostly from a small pool so removes find matches
    function automatic in_beat_t random_op(input mix_t mix);
        int       roll;
        action_t  a;
        in_beat_t b;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  a = (roll < 70) ? ACT_INSERT : (roll < 85) ? ACT_CHANGE :
                           (roll < 90) ? ACT_REMOVE : ACT_EXTRACT;
            MIX_DRAIN: a = (roll < 60) ? ACT_EXTRACT : (roll < 75) ? ACT_REMOVE :
                           (roll < 90) ? ACT_INSERT : ACT_CHANGE;
            default:   a = action_t'(roll % 4);
        endcase
        b.action = a;
        if ($urandom_range(0, 99) < 85)
            b.entry_id = id_pool[$urandom_range(0, 23)];
        else
            b.entry_id = ID_BITS'($urandom_range(0, 65535));
        roll = $urandom_range(0, 99);
        if (roll < 30)
            b.entry_priority = pri_pool[$urandom_range(0, 7)];
        else if (roll < 35)
            b.entry_priority = '0;
        else if (roll < 40)
            b.entry_priority = '1;
        else
            b.entry_priority = $urandom;
        return b;
    endfunction

    function automatic int pick_idle_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    task automatic cmp_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            errors++;
        end
    endtask

    // Clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Driver: offers beats from op_stream, with random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            in_data     <= '0;
            gap_left    <= 0;
            quiet       <= 1'b0;
            src_empty   <= 1'b0;
            tx_idle_pct <= 10;
        end
        else begin
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (op_stream.size() == 0) begin
                    in_valid <= 1'b0;
                end
                else if (op_stream[0].wait_drain && (in_valid || outstanding != 0)) begin
                    in_valid <= 1'b0;
                end
                else if (!quiet && tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
                    in_valid <= 1'b0;
                    gap_left <= $urandom_range(0, 6);
                end
                else begin
                    in_data  <= op_stream[0].beat;
                    in_valid <= 1'b1;
                    void'(op_stream.pop_front());
                    if ($urandom_range(0, 49) == 0)
                        tx_idle_pct <= pick_idle_rate();
                end
            end
            quiet     <= (op_stream.size() < 150);
            src_empty <= (op_stream.size() == 0);
        end
    end

    // Receiver: random stall bursts plus one long hold-off
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall   <= 1'b0;
            hold_left   <= 0;
            long_done   <= 1'b0;
            rx_idle_pct <= 10;
        end
        else begin
            if (!long_done && got_count >= 400) begin
                out_stall <= 1'b1;
                hold_left <= 300;
                long_done <= 1'b1;
            end
            else if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!quiet && rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                out_stall <= 1'b1;
                hold_left <= $urandom_range(0, 6);
            end
            else begin
                out_stall <= 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                rx_idle_pct <= pick_idle_rate();
        end
    end

    // Monitor: predict on each input beat, check each output beat
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            outstanding <= 0;
            got_count   <= 0;
        end
        else begin
            if (in_valid && !in_stall)
                op_results_q.push_back(apply_queue_op(in_data));
            if (out_valid && !out_stall) begin
                if (op_results_q.size() == 0) begin
                    $error("result beat with no operation pending");
                    errors++;
                end
                else begin
                    want = op_results_q.pop_front();
                    cmp_field("ok",           64'(want.ok),           64'(out_data.ok));
                    cmp_field("min_id",       64'(want.min_id),       64'(out_data.min_id));
                    cmp_field("min_priority", 64'(want.min_priority),
                              64'(out_data.min_priority));
                    cmp_field("is_empty",     64'(want.is_empty),     64'(out_data.is_empty));
                    cmp_field("overflow",     64'(want.overflow),     64'(out_data.overflow));
                end
                got_count <= got_count + 1;
            end
            outstanding <= op_results_q.size();
        end
    end

    // Stimulus, reset and end of run
    initial begin
        mix_t mix;
        int   n;
        int   len;
        errors = 0;
        q_cnt  = 0;
        rst_n  = 1'b0;

        for (int i = 0; i < 24; i++)
            id_pool[i] = ID_BITS'($urandom_range(0, 65535));
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 0; i < 8; i++)
            pri_pool[i] = $urandom_range(0, 15) << 16;

        // Directed: empty-queue cases, head ties, duplicates, first-match removal
        op_stream.push_back('{mk_beat(ACT_EXTRACT, 16'h0000, 32'h0000_0000), 1'b0});
        op_stream.push_back('{mk_beat(ACT_REMOVE,  16'h0005, 32'h0000_0000), 1'b0});
        op_stream.push_back('{mk_beat(ACT_CHANGE,  16'h0007, 32'h0000_0100), 1'b0});
        op_stream.push_back('{mk_beat(ACT_INSERT,  16'hFFFF, 32'hFFFF_FFFF), 1'b0});
        op_stream.push_back('{mk_beat(ACT_INSERT,  16'h0000, 32'h0000_0000), 1'b0});
        op_stream.push_back('{mk_beat(ACT_INSERT,  16'h0001, 32'h0000_0000), 1'b0});
        op_stream.push_back('{mk_beat(ACT_INSERT,  16'h0002, 32'h0000_0100), 1'b0});
        op_stream.push_back('{mk_beat(ACT_INSERT,  16'h0003, 32'h0000_0100), 1'b0});
        op_stream.push_back('{mk_beat(ACT_INSERT,  16'hFFFF, 32'h0000_8000), 1'b0});
        op_stream.push_back('{mk_beat(ACT_REMOVE,  16'hFFFF, 32'h0000_0000), 1'b0});
        op_stream.push_back('{mk_beat(ACT_CHANGE,  16'h0001, 32'hFFFF_FFFF), 1'b0});
        op_stream.push_back('{mk_beat(ACT_CHANGE,  16'h0000, 32'h0000_0000), 1'b0});
        op_stream.push_back('{mk_beat(ACT_REMOVE,  16'h1234, 32'hFFFF_FFFF), 1'b0});
        op_stream.push_back('{mk_beat(ACT_INSERT,  16'hA5A5, 32'h5A5A_5A5A), 1'b0});
        for (int i = 0; i < 9; i++)
            op_stream.push_back('{mk_beat(ACT_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF), 1'b0});

        // Random: fill to overflow first, drain to empty, then mixed segments
        n = 0;
        while (n < 1650) begin
            if (n == 0)
                mix = MIX_FILL;
            else if (n < 300)
                mix = MIX_DRAIN;
            else
                mix = mix_t'($urandom_range(0, 2));
            len = (n < 300) ? 150 : $urandom_range(40, 150);
            if (len > 1650 - n)
                len = 1650 - n;
            for (int i = 0; i < len; i++) begin
                op_stream.push_back('{random_op(mix), (i == 0 && n == 0)});
                n++;
            end
        end
        op_stream[1000].wait_drain = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (!src_empty || in_valid || outstanding != 0);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
design/spq_pkg.sv
design/spq_cell.sv
design/spq_prefix.sv
design/spq_chain.sv
design/spq_ctrl.sv
design/sorted_priority_queue_core.sv
tb/testbench.sv
